// File: hw/rtl/undirected_cycle_detect_defines.svh
// Assertion macros shared by the cycle detector RTL.
`ifndef UNDIRECTED_CYCLE_DETECT_DEFINES_SVH
`define UNDIRECTED_CYCLE_DETECT_DEFINES_SVH

// Condition in one cycle implies consequence in the next.
`define UCD_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

// Condition holds at every edge out of reset.
`define UCD_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// File: hw/rtl/cdet_pkg.sv
// Types and constants for the undirected cycle detector.
`default_nettype none
package cdet_pkg;

  localparam int MAX_VERTICES_DEF = 1023;
  localparam int MAX_EDGES_DEF    = 4096;
  localparam int FIELD_W          = 10;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] first_vertex;
    logic [FIELD_W-1:0] second_vertex;
  } in_t;

  typedef struct packed {
    logic has_cycle;
    logic overflow;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_A,
    ST_ADD_B,
    ST_ROOT_RD,
    ST_ROOT_CHK,
    ST_TOP,
    ST_POP,
    ST_EDGE,
    ST_VTX,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/cdet_ram.sv
// Single-port-write, single-port-read synchronous RAM, read data registered.
`default_nettype none
module cdet_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a read of the entry being written returns the old contents
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/undirected_cycle_detect.sv
// Top level: edge loader, depth-first cycle search and graph clear sequencer.
`default_nettype none
`include "undirected_cycle_detect_defines.svh"
// Edges are loaded one per start pulse into adjacency lists held in RAM; an edge
// add keeps busy high while it makes one list write per endpoint, the first one
// overlapping the read of the second endpoint's head. A finish item runs a
// depth-first walk whose length follows the graph: a root tried passes ST_ROOT_RD
// and ST_ROOT_CHK, a half-edge followed ST_TOP, ST_EDGE and ST_VTX, and a stack
// pop ST_TOP and ST_POP, as the vertex, edge and stack RAMs have registered reads.
// The single result is shown for exactly one cycle on out_valid and cannot be held
// off, so the receiver must take it when it appears. After each result, and after
// reset, the vertex table (MAX_VERTICES+1 entries) is cleared one entry per cycle
// while busy stays high; configuration writes are taken at any time.
module undirected_cycle_detect #(
  parameter int MAX_VERTICES = cdet_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = cdet_pkg::MAX_EDGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire cdet_pkg::in_t                 in_data,
  output logic                               out_valid,
  output cdet_pkg::out_t                     out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cdet_pkg::FIELD_W-1:0]  cfg_data
);

  import cdet_pkg::*;

  localparam int NUM_SLOTS = MAX_VERTICES + 1;
  localparam int HALF_CAP  = 2 * MAX_EDGES;
  localparam int VW        = $clog2(NUM_SLOTS);
  localparam int RW        = $clog2(NUM_SLOTS + 1);
  localparam int LW        = $clog2(HALF_CAP + 1);
  localparam int EW        = $clog2(HALF_CAP);
  localparam int VTX_W     = 1 + LW;
  localparam int EDGE_W    = LW + VW;
  localparam int STK_W     = VW + VW + LW;
  localparam logic [LW-1:0] NIL_LINK  = LW'(HALF_CAP);
  localparam logic [VW-1:0] LAST_SLOT = VW'(NUM_SLOTS - 1);

  state_t state_r, state_nxt;

  logic [FIELD_W-1:0] vc_r;
  logic [LW-1:0]      total_r;
  logic               dropped_r;
  logic               cyc_r;
  logic [VW-1:0]      a_r, b_r, v_r, clr_r;
  logic               same_r;
  logic [RW-1:0]      root_r, top_r;
  logic [VW-1:0]      cur_node_r, cur_from_r;
  logic [LW-1:0]      cur_cur_r;

  // memory ports
  logic              vwe, ewe, swe;
  logic [VW-1:0]     vwaddr, vraddr;
  logic [VTX_W-1:0]  vwdata, vrd;
  logic [EW-1:0]     ewaddr, eraddr;
  logic [EDGE_W-1:0] ewdata, erd;
  logic [VW-1:0]     swaddr, sraddr;
  logic [STK_W-1:0]  swdata, srd;

  logic          v_seen;
  logic [LW-1:0] v_head, e_next, head_b;
  logic [VW-1:0] e_tgt;
  logic [RW-1:0] limit;
  logic          in_range, full, has_more, at_root, accept;

  cdet_ram #(.DEPTH(NUM_SLOTS), .WIDTH(VTX_W)) u_vtx (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vraddr), .rdata(vrd)
  );

  cdet_ram #(.DEPTH(HALF_CAP), .WIDTH(EDGE_W)) u_edge (
    .clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewdata), .raddr(eraddr), .rdata(erd)
  );

  cdet_ram #(.DEPTH(NUM_SLOTS), .WIDTH(STK_W)) u_stack (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata), .raddr(sraddr), .rdata(srd)
  );

  assign v_seen   = vrd[LW];
  assign v_head   = vrd[LW-1:0];
  assign e_next   = erd[EDGE_W-1:VW];
  assign e_tgt    = erd[VW-1:0];
  assign head_b   = same_r ? total_r : v_head;
  assign limit    = (32'(vc_r) > MAX_VERTICES) ? RW'(MAX_VERTICES) : RW'(vc_r);
  assign in_range = (32'(in_data.first_vertex) <= MAX_VERTICES) &&
                    (32'(in_data.second_vertex) <= MAX_VERTICES);
  assign full     = (32'(total_r) + 2) > HALF_CAP;
  assign has_more = cur_cur_r < total_r;
  assign at_root  = top_r == RW'(1);
  assign accept   = start && !busy;

  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:    if (clr_r == LAST_SLOT) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (in_data.opcode == OP_FINISH) state_nxt = ST_ROOT_RD;
          else if (in_range && !full)     state_nxt = ST_ADD_A;
        end
      end
      ST_ADD_A:    state_nxt = ST_ADD_B;
      ST_ADD_B:    state_nxt = ST_IDLE;
      ST_ROOT_RD:  state_nxt = (root_r > limit) ? ST_DONE : ST_ROOT_CHK;
      ST_ROOT_CHK: state_nxt = v_seen ? ST_ROOT_RD : ST_TOP;
      ST_TOP: begin
        if (has_more)     state_nxt = ST_EDGE;
        else if (at_root) state_nxt = ST_ROOT_RD;
        else              state_nxt = ST_POP;
      end
      ST_POP:      state_nxt = ST_TOP;
      ST_EDGE:     state_nxt = ST_VTX;
      ST_VTX: begin
        if (!v_seen)                         state_nxt = ST_TOP;
        else if (at_root || v_r != cur_from_r) state_nxt = ST_DONE;
        else                                 state_nxt = ST_TOP;
      end
      ST_DONE:     state_nxt = ST_CLEAR;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls and result strobe
  always_comb begin
    vwe = 1'b0; vwaddr = '0; vwdata = '0; vraddr = '0;
    ewe = 1'b0; ewaddr = '0; ewdata = '0; eraddr = '0;
    swe = 1'b0; swaddr = '0; swdata = '0; sraddr = '0;
    out_valid = 1'b0;
    out_data  = '{has_cycle: cyc_r, overflow: dropped_r};
    unique case (state_r)
      ST_CLEAR: begin
        vwe = 1'b1; vwaddr = clr_r; vwdata = {1'b0, NIL_LINK};
      end
      ST_IDLE:  vraddr = VW'(in_data.first_vertex);
      ST_ADD_A: begin
        ewe = 1'b1; ewaddr = total_r[EW-1:0]; ewdata = {v_head, b_r};
        vwe = 1'b1; vwaddr = a_r; vwdata = {1'b0, total_r};
        vraddr = b_r;
      end
      ST_ADD_B: begin
        ewe = 1'b1; ewaddr = EW'(total_r + LW'(1)); ewdata = {head_b, a_r};
        vwe = 1'b1; vwaddr = b_r; vwdata = {1'b0, LW'(total_r + LW'(1))};
      end
      ST_ROOT_RD:  vraddr = root_r[VW-1:0];
      ST_ROOT_CHK: begin
        if (!v_seen) begin
          vwe = 1'b1; vwaddr = root_r[VW-1:0]; vwdata = {1'b1, v_head};
        end
      end
      ST_TOP: begin
        if (has_more)      eraddr = cur_cur_r[EW-1:0];
        else if (!at_root) sraddr = VW'(top_r - RW'(2));
      end
      ST_EDGE: vraddr = e_tgt;
      ST_VTX: begin
        if (!v_seen) begin
          vwe = 1'b1; vwaddr = v_r; vwdata = {1'b1, v_head};
          swe = 1'b1; swaddr = VW'(top_r - RW'(1));
          swdata = {cur_node_r, cur_from_r, cur_cur_r};
        end
      end
      ST_POP: ;
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      vc_r      <= '0;
      total_r   <= '0;
      dropped_r <= 1'b0;
      cyc_r     <= 1'b0;
      clr_r     <= '0;
      top_r     <= '0;
      root_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) vc_r <= cfg_data;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + VW'(1);
        ST_IDLE: begin
          if (accept) begin
            a_r    <= VW'(in_data.first_vertex);
            b_r    <= VW'(in_data.second_vertex);
            same_r <= in_data.first_vertex == in_data.second_vertex;
            root_r <= RW'(1);
            cyc_r  <= 1'b0;
            if (in_data.opcode == OP_ADD && in_range && full) dropped_r <= 1'b1;
          end
        end
        ST_ADD_B: total_r <= total_r + LW'(2);
        ST_ROOT_CHK: begin
          if (v_seen) begin
            root_r <= root_r + RW'(1);
          end else begin
            cur_node_r <= root_r[VW-1:0];
            cur_from_r <= '0;
            cur_cur_r  <= v_head;
            top_r      <= RW'(1);
          end
        end
        ST_TOP: begin
          if (!has_more && at_root) begin
            root_r <= root_r + RW'(1);
            top_r  <= '0;
          end
        end
        ST_POP: begin
          {cur_node_r, cur_from_r, cur_cur_r} <= srd;
          top_r <= top_r - RW'(1);
        end
        ST_EDGE: begin
          cur_cur_r <= e_next;
          v_r       <= e_tgt;
        end
        ST_VTX: begin
          if (!v_seen) begin
            cur_node_r <= v_r;
            cur_from_r <= cur_node_r;
            cur_cur_r  <= v_head;
            top_r      <= top_r + RW'(1);
          end else if (at_root || v_r != cur_from_r) begin
            cyc_r <= 1'b1;
          end
        end
        ST_DONE: begin
          total_r   <= '0;
          dropped_r <= 1'b0;
          clr_r     <= '0;
          top_r     <= '0;
        end
        default: ;
      endcase
    end
  end

  `UCD_ASSERT_NEXT(a_clear_after_result, out_valid, busy && !out_valid, "no clear after result")
  `UCD_ASSERT_NEXT(a_finish_not_instant, accept && in_data.opcode == OP_FINISH, !out_valid,
                   "result in the cycle after finish")
  `UCD_ASSERT_HOLD(a_stack_bound, 32'(top_r) <= NUM_SLOTS, "stack depth above vertex slots")
  `UCD_ASSERT_HOLD(a_edge_bound, 32'(total_r) <= HALF_CAP, "half-edge count above capacity")
  `UCD_ASSERT_NEXT(a_add_bumps_total, state_r == ST_ADD_B,
                   total_r == $past(total_r) + LW'(2), "edge add lost a half-edge")

endmodule
`default_nettype wire
